// ----- sv/image_rotate_flip_address_core_assert.svh -----
// Assertion macros shared by the rotate/flip address core.
`ifndef IMAGE_ROTATE_FLIP_ADDRESS_CORE_ASSERT_SVH
`define IMAGE_ROTATE_FLIP_ADDRESS_CORE_ASSERT_SVH

// same-cycle implication
`define IRFA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("irfa assertion failed");

// next-cycle implication
`define IRFA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("irfa assertion failed");

`endif

// ----- sv/irfa_pkg.sv -----
`default_nettype none

package irfa_pkg;

    localparam int MODE_W     = 3;
    localparam int DIM_W      = 13;
    localparam int STRIDE_W   = 14;
    localparam int PB_W       = 2;
    localparam int PIX_W      = 16;
    localparam int COORD_W    = 12;
    localparam int OFF_W      = 25;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;
    localparam int MAX_DIM_DEF = 4096;

    typedef enum logic [MODE_W-1:0] {
        MODE_TRANSPOSE = 3'd0,
        MODE_ROT_LEFT  = 3'd1,
        MODE_ROT_RIGHT = 3'd2,
        MODE_FLIP_V    = 3'd3,
        MODE_FLIP_H    = 3'd4
    } irfa_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE   = 3'd0,
        REG_WIDTH  = 3'd1,
        REG_HEIGHT = 3'd2,
        REG_STRIDE = 3'd3,
        REG_PBYTES = 3'd4
    } irfa_reg_t;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
        logic [STRIDE_W-1:0] stride;
        logic [PB_W-1:0]     pbytes;
    } irfa_cfg_t;

    // stage 1 -> stage 2 payload
    typedef struct packed {
        logic [PIX_W-1:0]   pixel;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
    } irfa_coord_t;

endpackage

`default_nettype wire

// ----- sv/irfa_cfg_regs.sv -----
`default_nettype none

module irfa_cfg_regs
    import irfa_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output irfa_cfg_t                  cfg
);

    irfa_cfg_t cfg_reg;
    irfa_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_MODE:   cfg_next.mode   = cfg_wdata[MODE_W-1:0];
                REG_WIDTH:  cfg_next.width  = cfg_wdata[DIM_W-1:0];
                REG_HEIGHT: cfg_next.height = cfg_wdata[DIM_W-1:0];
                REG_STRIDE: cfg_next.stride = cfg_wdata[STRIDE_W-1:0];
                REG_PBYTES: cfg_next.pbytes = cfg_wdata[PB_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode   <= MODE_TRANSPOSE;
            cfg_reg.width  <= DIM_W'(1);
            cfg_reg.height <= DIM_W'(1);
            cfg_reg.stride <= STRIDE_W'(1);
            cfg_reg.pbytes <= PB_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- sv/irfa_coord.sv -----
`default_nettype none

`include "image_rotate_flip_address_core_assert.svh"

module irfa_coord
    import irfa_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  irfa_cfg_t             cfg,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [PIX_W-1:0] pixel,
    output logic                  s1_valid,
    input  wire logic             s1_ready,
    output irfa_coord_t           s1_data
);

    // dimension registers are DIM_W bits, so larger limits never clamp
    localparam int DIM_CAP = (MAX_DIM > (2**DIM_W - 1)) ? (2**DIM_W - 1) : MAX_DIM;
    localparam int CNT_W   = $clog2(DIM_CAP);
    localparam logic [DIM_W-1:0] DIM_CLAMP = DIM_W'(DIM_CAP);

    logic [CNT_W-1:0] src_col_reg, src_col_next;
    logic [CNT_W-1:0] src_row_reg, src_row_next;
    logic             v1_reg, v1_next;
    irfa_coord_t      s1_reg, s1_next;

    logic [DIM_W-1:0] w_eff, h_eff, x_ext, y_ext, w_mirror, h_mirror;
    logic             last_col, last_row, accept;

    always_comb
    begin
        if (cfg.width == '0)
            w_eff = DIM_W'(1);
        else if (32'(cfg.width) > MAX_DIM)
            w_eff = DIM_CLAMP;
        else
            w_eff = cfg.width;

        if (cfg.height == '0)
            h_eff = DIM_W'(1);
        else if (32'(cfg.height) > MAX_DIM)
            h_eff = DIM_CLAMP;
        else
            h_eff = cfg.height;
    end

    assign x_ext    = DIM_W'(src_col_reg);
    assign y_ext    = DIM_W'(src_row_reg);
    assign last_col = x_ext >= (w_eff - DIM_W'(1));
    assign last_row = y_ext >= (h_eff - DIM_W'(1));
    // mirrored coordinates wrap if a counter sits past a shrunk size
    assign w_mirror = w_eff - DIM_W'(1) - x_ext;
    assign h_mirror = h_eff - DIM_W'(1) - y_ext;

    assign in_ready = !v1_reg || s1_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        s1_next       = s1_reg;
        s1_next.pixel = pixel;
        s1_next.last  = last_col && last_row;
        case (cfg.mode)
            MODE_ROT_LEFT:
            begin
                s1_next.row = w_mirror[COORD_W-1:0];
                s1_next.col = y_ext[COORD_W-1:0];
            end
            MODE_ROT_RIGHT:
            begin
                s1_next.row = x_ext[COORD_W-1:0];
                s1_next.col = h_mirror[COORD_W-1:0];
            end
            MODE_FLIP_V:
            begin
                s1_next.row = h_mirror[COORD_W-1:0];
                s1_next.col = x_ext[COORD_W-1:0];
            end
            MODE_FLIP_H:
            begin
                s1_next.row = y_ext[COORD_W-1:0];
                s1_next.col = w_mirror[COORD_W-1:0];
            end
            default:
            begin
                s1_next.row = x_ext[COORD_W-1:0];
                s1_next.col = y_ext[COORD_W-1:0];
            end
        endcase

        src_col_next = src_col_reg;
        src_row_next = src_row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                src_col_next = '0;
                src_row_next = last_row ? '0 : src_row_reg + 1'b1;
            end
            else
            begin
                src_col_next = src_col_reg + 1'b1;
            end
        end

        v1_next = v1_reg;
        if (accept)
            v1_next = 1'b1;
        else if (s1_ready)
            v1_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg <= '0;
            src_row_reg <= '0;
            v1_reg      <= 1'b0;
        end
        else
        begin
            src_col_reg <= src_col_next;
            src_row_reg <= src_row_next;
            v1_reg      <= v1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_reg <= s1_next;
    end

    assign s1_valid = v1_reg;
    assign s1_data  = s1_reg;

    `IRFA_ASSERT_NXT(a_s1_hold, clk, rst_n, v1_reg && !s1_ready, v1_reg && $stable(s1_reg))
    `IRFA_ASSERT_NXT(a_frame_wrap, clk, rst_n, accept && last_col && last_row, src_col_reg == '0 && src_row_reg == '0)
    `IRFA_ASSERT_NXT(a_col_step, clk, rst_n, accept && !last_col, src_col_reg == $past(src_col_reg) + 1'b1)
    `IRFA_ASSERT_NXT(a_cnt_idle, clk, rst_n, !accept, $stable(src_col_reg) && $stable(src_row_reg))

endmodule

`default_nettype wire

// ----- sv/irfa_offset.sv -----
`default_nettype none

module irfa_offset
    import irfa_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  irfa_cfg_t                cfg,
    input  wire logic                s1_valid,
    output logic                     s1_ready,
    input  irfa_coord_t              s1_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [PIX_W-1:0]         pixel_out,
    output logic [COORD_W-1:0]       dst_row,
    output logic [COORD_W-1:0]       dst_col,
    output logic [OFF_W-1:0]         dst_offset,
    output logic                     frame_last
);

    logic [COORD_W+STRIDE_W-1:0] row_bytes;
    logic [COORD_W:0]            col_bytes;
    logic [OFF_W-1:0]            offset_next;
    logic                        v2_reg, v2_next, load;

    logic [PIX_W-1:0]   pixel_reg;
    logic [COORD_W-1:0] row_reg, col_reg;
    logic [OFF_W-1:0]   offset_reg;
    logic               last_reg;

    assign row_bytes   = s1_data.row * cfg.stride;
    // pixel_bytes codes 2 and 3 mean two bytes, 0 and 1 mean one
    assign col_bytes   = cfg.pbytes[1] ? {s1_data.col, 1'b0} : {1'b0, s1_data.col};
    assign offset_next = row_bytes[OFF_W-1:0] + OFF_W'(col_bytes);

    assign s1_ready = !v2_reg || out_ready;
    assign load     = s1_valid && s1_ready;

    always_comb
    begin
        v2_next = v2_reg;
        if (load)
            v2_next = 1'b1;
        else if (out_ready)
            v2_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v2_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pixel_reg  <= s1_data.pixel;
            row_reg    <= s1_data.row;
            col_reg    <= s1_data.col;
            offset_reg <= offset_next;
            last_reg   <= s1_data.last;
        end
    end

    assign out_valid  = v2_reg;
    assign pixel_out  = pixel_reg;
    assign dst_row    = row_reg;
    assign dst_col    = col_reg;
    assign dst_offset = offset_reg;
    assign frame_last = last_reg;

endmodule

`default_nettype wire

// ----- sv/image_rotate_flip_address_core.sv -----
// Rotate/flip destination address generator, two register stages.
// A pixel accepted into the stage-1 register passes into the stage-2 register and is then valid on the output.
// Throughput: one transaction per cycle while out_ready stays high; the stage-2 multiply and add set the clock limit.
// Input ready depends only on the pipeline registers and output ready.
// Reset (rst_n, async, active low) empties both stages, zeroes the raster counters
// and returns the registers to mode 0, width 1, height 1, stride 1, one byte per pixel.
`default_nettype none

module image_rotate_flip_address_core
    import irfa_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [PIX_W-1:0]      pixel,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [PIX_W-1:0]           pixel_out,
    output logic [COORD_W-1:0]         dst_row,
    output logic [COORD_W-1:0]         dst_col,
    output logic [OFF_W-1:0]           dst_offset,
    output logic                       frame_last
);

    irfa_cfg_t   cfg;
    irfa_coord_t s1_data;
    logic        s1_valid, s1_ready;

    irfa_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    irfa_coord #(
        .MAX_DIM (MAX_DIM)
    ) u_coord (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .pixel    (pixel),
        .s1_valid (s1_valid),
        .s1_ready (s1_ready),
        .s1_data  (s1_data)
    );

    irfa_offset u_offset (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .s1_valid   (s1_valid),
        .s1_ready   (s1_ready),
        .s1_data    (s1_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_out  (pixel_out),
        .dst_row    (dst_row),
        .dst_col    (dst_col),
        .dst_offset (dst_offset),
        .frame_last (frame_last)
    );

endmodule

`default_nettype wire

// ----- tb/image_rotate_flip_address_core_checker.sv -----
`default_nettype none

module image_rotate_flip_address_core_checker
    import irfa_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  in_valid,
    input  wire logic                  in_ready,
    input  wire logic [PIX_W-1:0]      pixel,
    input  wire logic                  out_valid,
    input  wire logic                  out_ready,
    input  wire logic [PIX_W-1:0]      pixel_out,
    input  wire logic [COORD_W-1:0]    dst_row,
    input  wire logic [COORD_W-1:0]    dst_col,
    input  wire logic [OFF_W-1:0]      dst_offset,
    input  wire logic                  frame_last,
    output int                         fail_count,
    output int                         outstanding,
    output int                         results_checked,
    output int                         frame_ends
);

    typedef struct packed {
        logic [PIX_W-1:0]   pix;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [OFF_W-1:0]   offset;
        logic               last;
    } dest_pixel_t;

    dest_pixel_t dest_q[$];

    // shadow of the register file and the raster position
    logic [MODE_W-1:0]   shadow_mode;
    logic [DIM_W-1:0]    shadow_width;
    logic [DIM_W-1:0]    shadow_height;
    logic [STRIDE_W-1:0] shadow_stride;
    logic [PB_W-1:0]     shadow_pbytes;
    logic [COORD_W-1:0]  raster_col;
    logic [COORD_W-1:0]  raster_row;

    function automatic logic [31:0] clamp_dim(logic [DIM_W-1:0] v);
        if (v == '0)
            return 32'd1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return {19'd0, v};
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count      = 0;
        outstanding     = 0;
        results_checked = 0;
        frame_ends      = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] pb;
        logic [31:0] row_full;
        logic [31:0] col_full;
        logic [63:0] off_full;
        logic        last_col;
        logic        last_row;
        dest_pixel_t want;
        if (!rst_n)
        begin
            shadow_mode   = MODE_TRANSPOSE;
            shadow_width  = DIM_W'(1);
            shadow_height = DIM_W'(1);
            shadow_stride = STRIDE_W'(1);
            shadow_pbytes = PB_W'(1);
            raster_col    = '0;
            raster_row    = '0;
            dest_q.delete();
            outstanding   = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_MODE:   shadow_mode   = cfg_wdata[MODE_W-1:0];
                    REG_WIDTH:  shadow_width  = cfg_wdata[DIM_W-1:0];
                    REG_HEIGHT: shadow_height = cfg_wdata[DIM_W-1:0];
                    REG_STRIDE: shadow_stride = cfg_wdata[STRIDE_W-1:0];
                    REG_PBYTES: shadow_pbytes = cfg_wdata[PB_W-1:0];
                    default: ;
                endcase
            end

            // output side first, so a same-edge input cannot satisfy a stray result
            if (out_valid && out_ready)
            begin
                if (dest_q.size() == 0)
                    report_mismatch("result with no pixel pending", {16'd0, pixel_out}, 32'd0);
                else
                begin
                    want = dest_q.pop_front();
                    if (pixel_out !== want.pix)
                        report_mismatch("pixel_out", pixel_out, want.pix);
                    if (dst_row !== want.row)
                        report_mismatch("dst_row", dst_row, want.row);
                    if (dst_col !== want.col)
                        report_mismatch("dst_col", dst_col, want.col);
                    if (dst_offset !== want.offset)
                        report_mismatch("dst_offset", dst_offset, want.offset);
                    if (frame_last !== want.last)
                        report_mismatch("frame_last", frame_last, want.last);
                    results_checked++;
                    if (want.last)
                        frame_ends++;
                end
            end

            if (in_valid && in_ready)
            begin
                w  = clamp_dim(shadow_width);
                h  = clamp_dim(shadow_height);
                pb = shadow_pbytes[1] ? 32'd2 : 32'd1;
                last_col = {20'd0, raster_col} >= w - 1;
                last_row = {20'd0, raster_row} >= h - 1;
                case (shadow_mode)
                    MODE_ROT_LEFT:
                    begin
                        row_full = w - 1 - raster_col;
                        col_full = raster_row;
                    end
                    MODE_ROT_RIGHT:
                    begin
                        row_full = raster_col;
                        col_full = h - 1 - raster_row;
                    end
                    MODE_FLIP_V:
                    begin
                        row_full = h - 1 - raster_row;
                        col_full = raster_col;
                    end
                    MODE_FLIP_H:
                    begin
                        row_full = raster_row;
                        col_full = w - 1 - raster_col;
                    end
                    default:
                    begin
                        row_full = raster_col;
                        col_full = raster_row;
                    end
                endcase
                want.pix    = pixel;
                want.row    = row_full[COORD_W-1:0];
                want.col    = col_full[COORD_W-1:0];
                off_full    = want.row * shadow_stride + want.col * pb;
                want.offset = off_full[OFF_W-1:0];
                want.last   = last_col && last_row;
                dest_q.push_back(want);

                if (last_col)
                begin
                    raster_col = '0;
                    raster_row = last_row ? '0 : raster_row + 1'b1;
                end
                else
                    raster_col = raster_col + 1'b1;
            end

            outstanding = dest_q.size();
        end
    end

endmodule

`default_nettype wire

// ----- tb/image_rotate_flip_address_core_test.sv -----
`default_nettype none

module image_rotate_flip_address_core_test;
    import irfa_pkg::*;

    localparam int RANDOM_PIXELS = 2000;
    localparam int IDLE_LIMIT    = 1000;
    localparam int HOLD_CYCLES   = 60;
    // mode codes with no name of their own; the block treats them as transpose
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  in_valid;
    wire logic             in_ready;
    logic [PIX_W-1:0]      pixel;
    wire logic             out_valid;
    logic                  out_ready;
    wire logic [PIX_W-1:0]   pixel_out;
    wire logic [COORD_W-1:0] dst_row;
    wire logic [COORD_W-1:0] dst_col;
    wire logic [OFF_W-1:0]   dst_offset;
    wire logic               frame_last;

    int fail_count;
    int outstanding;
    int results_checked;
    int frame_ends;
    int pixels_sent;
    int settings_applied;
    int idle_cycles;
    bit no_idle;

    image_rotate_flip_address_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel      (pixel),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_out  (pixel_out),
        .dst_row    (dst_row),
        .dst_col    (dst_col),
        .dst_offset (dst_offset),
        .frame_last (frame_last)
    );

    image_rotate_flip_address_core_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .pixel           (pixel),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pixel_out       (pixel_out),
        .dst_row         (dst_row),
        .dst_col         (dst_col),
        .dst_offset      (dst_offset),
        .frame_last      (frame_last),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .frame_ends      (frame_ends)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // no-progress watchdog
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: random back-pressure, two long hold-offs to fill the pipe
    initial
    begin
        int stall;
        int n_taken;
        out_ready = 1'b0;
        n_taken   = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (n_taken == 300 || n_taken == 1300)
                stall = HOLD_CYCLES;
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            n_taken++;
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] value);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pixels_sent++;
    endtask

    task automatic drain_pipeline();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input irfa_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_setting(input logic [CFG_DATA_W-1:0] m,
                                 input logic [CFG_DATA_W-1:0] w,
                                 input logic [CFG_DATA_W-1:0] h,
                                 input logic [CFG_DATA_W-1:0] stride,
                                 input logic [CFG_DATA_W-1:0] pb);
        drain_pipeline();
        write_reg(REG_MODE, m);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_STRIDE, stride);
        write_reg(REG_PBYTES, pb);
        settings_applied++;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return CFG_DATA_W'(4096);
            2:       return CFG_DATA_W'(8191);
            3:       return CFG_DATA_W'($urandom_range(4097, 8191));
            4:       return CFG_DATA_W'($urandom_range(9, 4095));
            default: return CFG_DATA_W'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_stride();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CFG_DATA_W'(16383);
            2:       return CFG_DATA_W'($urandom_range(0, 16383));
            default: return CFG_DATA_W'($urandom_range(1, 64));
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return PIX_W'($urandom_range(0, 65535));
        endcase
    endfunction

    initial
    begin
        int phase_len;
        int random_sent;
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = REG_MODE;
        cfg_wdata        = '0;
        in_valid         = 1'b0;
        pixel            = '0;
        no_idle          = 1'b0;
        pixels_sent      = 0;
        settings_applied = 0;
        idle_cycles      = 0;
        random_sent      = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset values: one-pixel frames
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);

        // oversized width, zero height, max stride (offset wraps), pixel size 3
        apply_setting(CFG_DATA_W'(MODE_ROT_LEFT), CFG_DATA_W'(8191), CFG_DATA_W'(0),
                      CFG_DATA_W'(16383), CFG_DATA_W'(3));
        send_pixel(16'hA5A5);
        send_pixel(16'h5A5A);
        send_pixel(16'h8001);

        // spare mode code, zero stride, pixel size 0; column counter starts on the last column of the new width
        apply_setting(CFG_DATA_W'(MODE_SPARE_HI), CFG_DATA_W'(4), CFG_DATA_W'(3),
                      CFG_DATA_W'(0), CFG_DATA_W'(0));
        repeat (7) send_pixel(pick_pixel());

        // shrink width mid-frame so the mirrored column wraps
        apply_setting(CFG_DATA_W'(MODE_FLIP_H), CFG_DATA_W'(2), CFG_DATA_W'(3),
                      CFG_DATA_W'(0), CFG_DATA_W'(0));
        send_pixel(16'h00FF);
        send_pixel(16'hFF00);

        apply_setting(CFG_DATA_W'(MODE_ROT_RIGHT), CFG_DATA_W'(4096), CFG_DATA_W'(4096),
                      CFG_DATA_W'(8192), CFG_DATA_W'(2));
        repeat (3) send_pixel(pick_pixel());

        // one-byte pixels still carry the upper byte
        apply_setting(CFG_DATA_W'(MODE_FLIP_V), CFG_DATA_W'(1), CFG_DATA_W'(2),
                      CFG_DATA_W'(1), CFG_DATA_W'(1));
        repeat (4) send_pixel(16'h12FF);

        apply_setting(CFG_DATA_W'(MODE_TRANSPOSE), CFG_DATA_W'(3), CFG_DATA_W'(2),
                      CFG_DATA_W'(5), CFG_DATA_W'(1));
        repeat (2) send_pixel(pick_pixel());
        apply_setting(CFG_DATA_W'(MODE_SPARE_LO), CFG_DATA_W'(3), CFG_DATA_W'(2),
                      CFG_DATA_W'(5), CFG_DATA_W'(2));
        send_pixel(16'h7FFF);

        while (random_sent < RANDOM_PIXELS)
        begin
            apply_setting(CFG_DATA_W'($urandom_range(0, 7)), pick_dim(), pick_dim(),
                          pick_stride(), CFG_DATA_W'($urandom_range(0, 3)));
            no_idle   = ($urandom_range(0, 4) == 0);
            phase_len = $urandom_range(16, 160);
            repeat (phase_len) send_pixel(pick_pixel());
            random_sent += phase_len;
        end

        no_idle = 1'b0;
        drain_pipeline();
        repeat (8) @(negedge clk);
        $display("covered %0d pixels over %0d register settings, all five modes and spare codes",
                 pixels_sent, settings_applied);
        $display("checked %0d results, %0d frame ends, %0d mismatches",
                 results_checked, frame_ends, fail_count);
        if (fail_count == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
